/* rtl/core/mtep_pkg.sv */
// ----------------------------------------------------------------------------
// mtep_pkg: shared definitions for the midi track event parser
// Record kinds, field widths and the result record type.
// ----------------------------------------------------------------------------
`default_nettype none

package mtep_pkg;

    // default longest delta time in bytes
    localparam int MaxDeltaBytesDefault = 4;

    // field widths
    localparam int DeltaW = 28;
    localparam int TempoW = 24;
    localparam int KindW  = 3;

    // meta event codes
    localparam logic [7:0] StatusMeta = 8'hFF;
    localparam logic [7:0] MetaEot    = 8'h2F;
    localparam logic [7:0] MetaTempo  = 8'h51;

    // result record kinds
    typedef enum logic [KindW-1:0] {
        KIND_CHANNEL  = 3'd0,
        KIND_META     = 3'd1,
        KIND_TEMPO    = 3'd2,
        KIND_EOT      = 3'd3,
        KIND_DELTA_OV = 3'd4
    } event_kind_t;

    // one result record
    typedef struct packed {
        event_kind_t       kind;
        logic [TempoW-1:0] tempo_micros;
        logic [7:0]        second_param;
        logic [7:0]        first_param;
        logic [3:0]        channel_number;
        logic [3:0]        event_type;
        logic [DeltaW-1:0] delta_ticks;
    } result_t;

endpackage

`default_nettype wire

/* rtl/core/midi_track_event_parser.sv */
// ----------------------------------------------------------------------------
// midi_track_event_parser: streaming parser for midi track body bytes
// Decodes delta times, channel events, meta headers, tempo and end of track.
// ----------------------------------------------------------------------------
// The block takes one track byte per beat and can accept a byte in every
// cycle; each byte is decoded in the cycle it is accepted, and a record it
// completes is registered into the output register, or into the skid entry
// while the output is held. An output register plus one skid entry keep the
// slave side open while a record waits, so the input only stalls once two
// records are pending. A byte with track_start set restarts the parse with
// that byte as the first delta time byte. After an end of track record or a
// delta too long record, bytes are dropped until track_start is seen again.
`default_nettype none

module midi_track_event_parser
    import mtep_pkg::*;
#(
    parameter int MAX_DELTA_BYTES = MaxDeltaBytesDefault
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // slave side
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic [0:0]  s_tuser,   // [0] track_start
    // master side
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [79:0]      m_tdata,   // [27:0] delta_ticks, [31:28] event_type,
                                        // [35:32] channel_number, [43:36] first_param,
                                        // [51:44] second_param, [75:52] tempo_micros
    output logic [2:0]       m_tuser    // [2:0] event_kind
);

    typedef enum logic [2:0] {
        PH_DELTA,
        PH_STATUS,
        PH_PARAM1,
        PH_PARAM2,
        PH_SKIP,
        PH_TEMPO,
        PH_HALT
    } phase_t;

    localparam logic [2:0] MaxDeltaCnt = 3'(MAX_DELTA_BYTES);

    phase_t             phase_reg, phase_next;
    logic [DeltaW-1:0]  delta_reg, delta_next;
    logic [2:0]         dcnt_reg, dcnt_next;
    logic [7:0]         status_reg, status_next;
    logic [7:0]         param_reg, param_next;
    logic [7:0]         skip_reg, skip_next;
    logic [TempoW-1:0]  tempo_reg, tempo_next;
    logic [1:0]         tcnt_reg, tcnt_next;

    result_t            out_reg, skid_reg, res_next;
    logic               out_valid_reg, skid_valid_reg;
    logic               res_valid;

    logic               accept, drain;
    logic [7:0]         b;

    assign b        = s_tdata;
    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign drain    = out_valid_reg && m_tready;

    // per-byte parse step
    always_comb begin
        phase_t             ph;
        logic [DeltaW-1:0]  dacc;
        logic [2:0]         dcnt;
        logic [7:0]         st;
        logic [7:0]         pr;
        logic [7:0]         sk;
        logic [TempoW-1:0]  tacc;
        logic [1:0]         tcnt;

        ph   = phase_reg;
        dacc = delta_reg;
        dcnt = dcnt_reg;
        st   = status_reg;
        pr   = param_reg;
        sk   = skip_reg;
        tacc = tempo_reg;
        tcnt = tcnt_reg;

        // restart before this byte
        if (s_tuser[0]) begin
            ph   = PH_DELTA;
            dacc = '0;
            dcnt = '0;
            st   = '0;
            pr   = '0;
            sk   = '0;
            tacc = '0;
            tcnt = '0;
        end

        res_valid = 1'b0;
        res_next  = '{kind: KIND_CHANNEL, default: '0};

        unique case (ph)
            PH_DELTA: begin
                dacc = {dacc[DeltaW-8:0], b[6:0]};
                dcnt = dcnt + 3'd1;
                if (!b[7]) begin
                    ph = PH_STATUS;
                end else if (dcnt >= MaxDeltaCnt) begin
                    st        = '0;
                    pr        = '0;
                    res_valid = 1'b1;
                    res_next  = '{kind: KIND_DELTA_OV, delta_ticks: dacc, default: '0};
                    ph        = PH_HALT;
                end
            end
            PH_STATUS: begin
                st = b;
                ph = PH_PARAM1;
            end
            PH_PARAM1: begin
                pr = b;
                ph = PH_PARAM2;
            end
            PH_PARAM2: begin
                res_next = '{kind: KIND_CHANNEL, delta_ticks: dacc, event_type: st[7:4],
                             channel_number: st[3:0], first_param: pr, second_param: b,
                             tempo_micros: '0};
                if (st != StatusMeta) begin
                    res_valid = 1'b1;
                    ph        = PH_DELTA;
                    dacc      = '0;
                    dcnt      = '0;
                end else begin
                    sk = b;
                    priority if (pr == MetaEot) begin
                        res_valid     = 1'b1;
                        res_next.kind = KIND_EOT;
                        ph            = PH_HALT;
                    end else if (pr == MetaTempo) begin
                        tacc = '0;
                        tcnt = '0;
                        ph   = PH_TEMPO;
                    end else begin
                        res_valid     = 1'b1;
                        res_next.kind = KIND_META;
                        if (b == 8'd0) begin
                            ph   = PH_DELTA;
                            dacc = '0;
                            dcnt = '0;
                        end else begin
                            ph = PH_SKIP;
                        end
                    end
                end
            end
            PH_SKIP: begin
                sk = sk - 8'd1;
                if (sk == 8'd0) begin
                    ph   = PH_DELTA;
                    dacc = '0;
                    dcnt = '0;
                end
            end
            PH_TEMPO: begin
                tacc = {tacc[TempoW-9:0], b};
                tcnt = tcnt + 2'd1;
                if (tcnt == 2'd3) begin
                    res_valid = 1'b1;
                    res_next  = '{kind: KIND_TEMPO, delta_ticks: dacc, event_type: st[7:4],
                                  channel_number: st[3:0], first_param: pr,
                                  second_param: sk, tempo_micros: tacc};
                    tcnt      = '0;
                    ph        = PH_DELTA;
                    dacc      = '0;
                    dcnt      = '0;
                end
            end
            PH_HALT: begin
            end
            default: begin
            end
        endcase

        phase_next  = ph;
        delta_next  = dacc;
        dcnt_next   = dcnt;
        status_next = st;
        param_next  = pr;
        skip_next   = sk;
        tempo_next  = tacc;
        tcnt_next   = tcnt;
    end

    // parse state, updated on each accepted beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_DELTA;
            delta_reg  <= '0;
            dcnt_reg   <= '0;
            status_reg <= '0;
            param_reg  <= '0;
            skip_reg   <= '0;
            tempo_reg  <= '0;
            tcnt_reg   <= '0;
        end else if (accept) begin
            phase_reg  <= phase_next;
            delta_reg  <= delta_next;
            dcnt_reg   <= dcnt_next;
            status_reg <= status_next;
            param_reg  <= param_next;
            skip_reg   <= skip_next;
            tempo_reg  <= tempo_next;
            tcnt_reg   <= tcnt_next;
        end
    end

    // output register with one skid entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            priority if (accept && res_valid && out_valid_reg && !drain) begin
                // output busy and held, park the new record
                skid_reg       <= res_next;
                skid_valid_reg <= 1'b1;
            end else if (drain && skid_valid_reg) begin
                // no beat can be taken while the skid entry is full
                out_reg        <= skid_reg;
                skid_valid_reg <= 1'b0;
            end else if (accept && res_valid) begin
                out_reg       <= res_next;
                out_valid_reg <= 1'b1;
            end else if (drain) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // master side packing
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tdata  = {4'd0, out_reg.tempo_micros, out_reg.second_param,
                       out_reg.first_param, out_reg.channel_number,
                       out_reg.event_type, out_reg.delta_ticks};

endmodule

`default_nettype wire
